// File: sv/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the stream find-and-replace block.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int SLOT_COUNT          = 16;
    localparam int MAX_PATTERN_DEF     = 16;
    localparam int MAX_REPLACEMENT_DEF = 16;
    localparam int CFG_DATA_W          = 64;
    localparam int CFG_INDEX_W         = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN_LOW      = 3'd0,
        CFG_PATTERN_HIGH     = 3'd1,
        CFG_PATTERN_LENGTH   = 3'd2,
        CFG_REPLACEMENT_LOW  = 3'd3,
        CFG_REPLACEMENT_HIGH = 3'd4,
        CFG_REPLACEMENT_LEN  = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        run_last;
        logic        stream_end;
        logic [31:0] replacements_done;
    } out_item_t;

    typedef struct packed {
        logic [8*SLOT_COUNT-1:0] pattern;
        logic [4:0]             pattern_length;
        logic [8*SLOT_COUNT-1:0] replacement;
        logic [4:0]             replacement_length;
    } cfg_t;

    typedef struct packed {
        logic        load;
        logic        stream_end;
        logic        byte_valid;
        logic [31:0] total;
    } job_ctl_t;

endpackage

// File: sv/sfr_cfg_regs.sv
// ----------------------------------------------------------------------------
// sfr_cfg_regs
// Configuration register file with plain write port.
// ----------------------------------------------------------------------------
module sfr_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [sfr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output sfr_pkg::cfg_t                     cfg
);
    import sfr_pkg::*;

    logic [63:0] pat_lo_reg, pat_hi_reg, rep_lo_reg, rep_hi_reg;
    logic [4:0]  pat_len_reg, rep_len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_lo_reg  <= '0;
            pat_hi_reg  <= '0;
            pat_len_reg <= 5'd1;
            rep_lo_reg  <= '0;
            rep_hi_reg  <= '0;
            rep_len_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_PATTERN_LOW:      pat_lo_reg  <= cfg_wdata;
                CFG_PATTERN_HIGH:     pat_hi_reg  <= cfg_wdata;
                CFG_PATTERN_LENGTH:   pat_len_reg <= cfg_wdata[4:0];
                CFG_REPLACEMENT_LOW:  rep_lo_reg  <= cfg_wdata;
                CFG_REPLACEMENT_HIGH: rep_hi_reg  <= cfg_wdata;
                CFG_REPLACEMENT_LEN:  rep_len_reg <= cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    assign cfg.pattern            = {pat_hi_reg, pat_lo_reg};
    assign cfg.pattern_length     = pat_len_reg;
    assign cfg.replacement        = {rep_hi_reg, rep_lo_reg};
    assign cfg.replacement_length = rep_len_reg;

endmodule

// File: sv/sfr_window.sv
// ----------------------------------------------------------------------------
// sfr_window
// Pending-byte window, parallel pattern compare and per-transaction job build.
// ----------------------------------------------------------------------------
module sfr_window #(
    parameter int MAX_PATTERN     = sfr_pkg::MAX_PATTERN_DEF,
    parameter int MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT_DEF,
    localparam int PAT_CAP   = (MAX_PATTERN < sfr_pkg::SLOT_COUNT) ?
                               MAX_PATTERN : sfr_pkg::SLOT_COUNT,
    localparam int REP_CAP   = (MAX_REPLACEMENT < sfr_pkg::SLOT_COUNT) ?
                               MAX_REPLACEMENT : sfr_pkg::SLOT_COUNT,
    localparam int JOB_DEPTH = (PAT_CAP > REP_CAP) ? PAT_CAP : REP_CAP,
    localparam int CNT_W     = $clog2(JOB_DEPTH + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  sfr_pkg::in_item_t             item,
    input  sfr_pkg::cfg_t                 cfg,
    output logic [JOB_DEPTH-1:0][7:0]     job_bytes,
    output logic [CNT_W-1:0]              job_count,
    output sfr_pkg::job_ctl_t             job_ctl
);
    import sfr_pkg::*;

    localparam int LEN_W = $clog2(PAT_CAP + 1);

    logic [PAT_CAP-1:0][7:0] win_reg, win_next;
    logic [LEN_W-1:0]        fill_reg, fill_next;
    logic [LEN_W-1:0]        act_len_reg;
    logic                    open_reg;
    logic [31:0]             total_reg, total_next;

    logic [4:0]              pat_len_clamp;
    logic [4:0]              rep_len_clamp;
    logic [LEN_W-1:0]        len;
    logic [LEN_W-1:0]        f1;
    logic [PAT_CAP-1:0][7:0] w1;
    logic [PAT_CAP-1:0]      slot_ok;
    logic                    full, match;
    logic [CNT_W-1:0]        count;

    always_comb begin
        if (cfg.pattern_length == 5'd0) begin
            pat_len_clamp = 5'd1;
        end else if (cfg.pattern_length > 5'(PAT_CAP)) begin
            pat_len_clamp = 5'(PAT_CAP);
        end else begin
            pat_len_clamp = cfg.pattern_length;
        end
        if (cfg.replacement_length > 5'(REP_CAP)) begin
            rep_len_clamp = 5'(REP_CAP);
        end else begin
            rep_len_clamp = cfg.replacement_length;
        end
    end

    assign len = open_reg ? act_len_reg : LEN_W'(pat_len_clamp);
    assign f1  = fill_reg + LEN_W'(1);

    always_comb begin
        for (int i = 0; i < PAT_CAP; i++) begin
            w1[i]      = (LEN_W'(i) == fill_reg) ? item.in_byte : win_reg[i];
            slot_ok[i] = (LEN_W'(i) >= len) || (w1[i] == cfg.pattern[8*i +: 8]);
        end
    end

    assign full  = (f1 == len);
    assign match = full && (&slot_ok);

    always_comb begin
        for (int i = 0; i < JOB_DEPTH; i++) begin
            job_bytes[i] = '0;
            if (match) begin
                if (i < REP_CAP) begin
                    job_bytes[i] = cfg.replacement[8*i +: 8];
                end
            end else begin
                if (i < PAT_CAP) begin
                    job_bytes[i] = w1[i];
                end
            end
        end
    end

    always_comb begin
        if (match) begin
            count = CNT_W'(rep_len_clamp);
        end else if (full) begin
            count = item.in_last ? CNT_W'(len) : CNT_W'(1);
        end else begin
            count = item.in_last ? CNT_W'(f1) : '0;
        end
    end

    always_comb begin
        job_ctl.stream_end = item.in_last;
        job_ctl.byte_valid = (count != '0);
        job_ctl.total      = total_next;
        job_count          = count;
        if (item.in_last && count == '0) begin
            job_count = CNT_W'(1);
        end
        job_ctl.load = accept && (job_count != '0);
    end

    assign total_next = (match && total_reg != 32'hFFFF_FFFF) ? total_reg + 32'd1
                                                              : total_reg;

    always_comb begin
        win_next = w1;
        if (full && !match) begin
            for (int i = 0; i + 1 < PAT_CAP; i++) begin
                win_next[i] = w1[i+1];
            end
        end
        if (match || item.in_last) begin
            fill_next = '0;
        end else if (full) begin
            fill_next = len - LEN_W'(1);
        end else begin
            fill_next = f1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            act_len_reg <= LEN_W'(1);
            open_reg    <= 1'b0;
            total_reg   <= '0;
        end else if (accept) begin
            fill_reg    <= fill_next;
            act_len_reg <= len;
            open_reg    <= !item.in_last;
            total_reg   <= item.in_last ? 32'd0 : total_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            win_reg <= win_next;
        end
    end

endmodule

// File: sv/sfr_out_queue.sv
// ----------------------------------------------------------------------------
// sfr_out_queue
// Result register that plays out one job's bytes, one transaction per cycle while m_ready is high.
// ----------------------------------------------------------------------------
module sfr_out_queue #(
    parameter int MAX_PATTERN     = sfr_pkg::MAX_PATTERN_DEF,
    parameter int MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT_DEF,
    localparam int PAT_CAP   = (MAX_PATTERN < sfr_pkg::SLOT_COUNT) ?
                               MAX_PATTERN : sfr_pkg::SLOT_COUNT,
    localparam int REP_CAP   = (MAX_REPLACEMENT < sfr_pkg::SLOT_COUNT) ?
                               MAX_REPLACEMENT : sfr_pkg::SLOT_COUNT,
    localparam int JOB_DEPTH = (PAT_CAP > REP_CAP) ? PAT_CAP : REP_CAP,
    localparam int CNT_W     = $clog2(JOB_DEPTH + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [JOB_DEPTH-1:0][7:0]     job_bytes,
    input  logic [CNT_W-1:0]              job_count,
    input  sfr_pkg::job_ctl_t             job_ctl,
    output logic                          free,
    output logic                          m_valid,
    input  logic                          m_ready,
    output sfr_pkg::out_item_t            m_payload
);
    import sfr_pkg::*;

    logic                      valid_reg;
    logic [JOB_DEPTH-1:0][7:0] bytes_reg;
    logic [CNT_W-1:0]          remain_reg;
    logic                      end_reg;
    logic                      bv_reg;
    logic [31:0]               total_reg;
    logic                      take, final_take;

    assign take       = valid_reg && m_ready;
    assign final_take = take && (remain_reg == CNT_W'(1));
    assign free       = !valid_reg || final_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (job_ctl.load) begin
            valid_reg <= 1'b1;
        end else if (final_take) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (job_ctl.load) begin
            bytes_reg  <= job_bytes;
            remain_reg <= job_count;
            end_reg    <= job_ctl.stream_end;
            bv_reg     <= job_ctl.byte_valid;
            total_reg  <= job_ctl.total;
        end else if (take) begin
            for (int i = 0; i + 1 < JOB_DEPTH; i++) begin
                bytes_reg[i] <= bytes_reg[i+1];
            end
            remain_reg <= remain_reg - CNT_W'(1);
        end
    end

    assign m_valid                     = valid_reg;
    assign m_payload.out_byte          = bv_reg ? bytes_reg[0] : 8'd0;
    assign m_payload.byte_valid        = bv_reg;
    assign m_payload.run_last          = (remain_reg == CNT_W'(1));
    assign m_payload.stream_end        = end_reg && (remain_reg == CNT_W'(1));
    assign m_payload.replacements_done = total_reg;

endmodule

// File: sv/stream_find_replace.sv
// ----------------------------------------------------------------------------
// stream_find_replace
// Streaming find-and-replace over a byte stream with an end marker.
// ----------------------------------------------------------------------------
// The first result of a transaction is registered and offered in the cycle after accept.
// Inputs are taken one per cycle while each input yields at most one result and m_ready is high;
//   an input yielding more than one result holds the result register until all are taken.
// Reset: synchronous, active low; control and config registers return to defaults, window empty,
//   replacement count zero.
module stream_find_replace #(
    parameter int MAX_PATTERN     = sfr_pkg::MAX_PATTERN_DEF,
    parameter int MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [sfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  sfr_pkg::in_item_t               s_payload,
    output logic                            m_valid,
    input  logic                            m_ready,
    output sfr_pkg::out_item_t              m_payload
);
    import sfr_pkg::*;

    localparam int PAT_CAP   = (MAX_PATTERN < SLOT_COUNT) ? MAX_PATTERN : SLOT_COUNT;
    localparam int REP_CAP   = (MAX_REPLACEMENT < SLOT_COUNT) ? MAX_REPLACEMENT
                                                              : SLOT_COUNT;
    localparam int JOB_DEPTH = (PAT_CAP > REP_CAP) ? PAT_CAP : REP_CAP;
    localparam int CNT_W     = $clog2(JOB_DEPTH + 1);

    cfg_t                      cfg;
    logic                      accept;
    logic [JOB_DEPTH-1:0][7:0] job_bytes;
    logic [CNT_W-1:0]          job_count;
    job_ctl_t                  job_ctl;

    assign accept = s_valid && s_ready;

    sfr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    sfr_window #(
        .MAX_PATTERN     (MAX_PATTERN),
        .MAX_REPLACEMENT (MAX_REPLACEMENT)
    ) u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .item      (s_payload),
        .cfg       (cfg),
        .job_bytes (job_bytes),
        .job_count (job_count),
        .job_ctl   (job_ctl)
    );

    sfr_out_queue #(
        .MAX_PATTERN     (MAX_PATTERN),
        .MAX_REPLACEMENT (MAX_REPLACEMENT)
    ) u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_bytes (job_bytes),
        .job_count (job_count),
        .job_ctl   (job_ctl),
        .free      (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

// File: verif/sfr_replace_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_replace_checker
// Watches the configuration port and both streams of the find-and-replace
// block. It keeps its own copy of the registers and of the pattern window,
// works out the result bytes of each accepted transaction and compares every
// result transaction with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module sfr_replace_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [sfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  sfr_pkg::in_item_t               s_payload,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  sfr_pkg::out_item_t              m_payload,
    output int                              mismatch_count,
    output int                              pending_count
);

    import sfr_pkg::*;

    logic [127:0] pattern_bits;
    logic [127:0] replacement_bits;
    logic [4:0]   pattern_len_reg;
    logic [4:0]   replacement_len_reg;

    logic [7:0]   slot_bytes [16];
    int           slot_fill;
    int           live_len;
    logic [31:0]  replace_count;
    bit           stream_open;

    out_item_t    expected_bytes [$];

    function automatic out_item_t text_item(input logic [7:0] b, input logic v);
        out_item_t t;
        t = '0;
        t.out_byte   = b;
        t.byte_valid = v;
        return t;
    endfunction

    task automatic report_mismatch(input string why, input out_item_t exp_t,
                                   input out_item_t got_t);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t: %s: expected byte %02h valid %0b last %0b end %0b count %0d",
                     $realtime, why, exp_t.out_byte, exp_t.byte_valid, exp_t.run_last,
                     exp_t.stream_end, exp_t.replacements_done);
            $display("%0t: %s:      got byte %02h valid %0b last %0b end %0b count %0d",
                     $realtime, why, got_t.out_byte, got_t.byte_valid, got_t.run_last,
                     got_t.stream_end, got_t.replacements_done);
        end
    endtask

    task automatic predict_replace(input in_item_t item);
        out_item_t run [17];
        int        n;
        int        i;
        int        r;
        bit        hit;
        n = 0;
        if (!stream_open) begin
            // pattern length is latched per stream
            live_len = (pattern_len_reg == 0) ? 1 :
                       ((pattern_len_reg > 16) ? 16 : int'(pattern_len_reg));
            stream_open = 1'b1;
        end
        if (slot_fill < live_len) begin
            slot_bytes[slot_fill] = item.in_byte;
            slot_fill++;
        end
        if (slot_fill == live_len) begin
            hit = 1'b1;
            for (i = 0; i < live_len; i++) begin
                if (slot_bytes[i] !== pattern_bits[8*i +: 8]) hit = 1'b0;
            end
            if (hit) begin
                r = (replacement_len_reg > 16) ? 16 : int'(replacement_len_reg);
                for (i = 0; i < r; i++) begin
                    run[n] = text_item(replacement_bits[8*i +: 8], 1'b1);
                    n++;
                end
                slot_fill = 0;
                if (replace_count != 32'hFFFF_FFFF) replace_count++;
            end else begin
                run[n] = text_item(slot_bytes[0], 1'b1);
                n++;
                for (i = 1; i < slot_fill; i++) slot_bytes[i-1] = slot_bytes[i];
                slot_fill--;
            end
        end
        if (item.in_last) begin
            for (i = 0; i < slot_fill; i++) begin
                run[n] = text_item(slot_bytes[i], 1'b1);
                n++;
            end
            slot_fill = 0;
            // empty end marker
            if (n == 0) begin
                run[n] = text_item(8'h00, 1'b0);
                n++;
            end
        end
        for (i = 0; i < n; i++) begin
            run[i].replacements_done = replace_count;
            if (i == n - 1) begin
                run[i].run_last   = 1'b1;
                run[i].stream_end = item.in_last;
            end
            expected_bytes.push_back(run[i]);
        end
        if (item.in_last) begin
            replace_count = '0;
            stream_open   = 1'b0;
        end
    endtask

    always @(posedge aclk) begin : watch
        out_item_t exp_t;
        if (!aresetn) begin
            pattern_bits        = '0;
            replacement_bits    = '0;
            pattern_len_reg     = 5'd1;
            replacement_len_reg = 5'd0;
            slot_fill           = 0;
            live_len            = 1;
            replace_count       = '0;
            stream_open         = 1'b0;
            expected_bytes.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_PATTERN_LOW:      pattern_bits[63:0]      = cfg_wdata;
                    CFG_PATTERN_HIGH:     pattern_bits[127:64]    = cfg_wdata;
                    CFG_PATTERN_LENGTH:   pattern_len_reg         = cfg_wdata[4:0];
                    CFG_REPLACEMENT_LOW:  replacement_bits[63:0]  = cfg_wdata;
                    CFG_REPLACEMENT_HIGH: replacement_bits[127:64] = cfg_wdata;
                    CFG_REPLACEMENT_LEN:  replacement_len_reg     = cfg_wdata[4:0];
                    default: ;
                endcase
            end
            // results first: they belong to transactions accepted earlier
            if (m_valid && m_ready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch("unexpected transaction", '0, m_payload);
                end else begin
                    exp_t = expected_bytes.pop_front();
                    if (m_payload.out_byte !== exp_t.out_byte ||
                        m_payload.byte_valid !== exp_t.byte_valid ||
                        m_payload.run_last !== exp_t.run_last ||
                        m_payload.stream_end !== exp_t.stream_end ||
                        m_payload.replacements_done !== exp_t.replacements_done) begin
                        report_mismatch("field mismatch", exp_t, m_payload);
                    end
                end
            end
            if (s_valid && s_ready) predict_replace(s_payload);
        end
        pending_count <= expected_bytes.size();
    end

endmodule

// File: verif/stream_find_replace_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_find_replace_tb
// Drives byte streams and register settings into the find-and-replace block
// with random gaps on both streams and long receiver stalls, and reports the
// verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module stream_find_replace_tb;

    import sfr_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 100;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_PATTERN_LOW;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    in_item_t               s_payload = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    out_item_t              m_payload;

    int mismatch_count;
    int pending_count;
    int idle_cycles;
    bit sender_calm;

    stream_find_replace dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    sfr_replace_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_payload      (s_payload),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_payload      (m_payload),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic load_setting(input logic [127:0] pat, input logic [63:0] pat_len_w,
                                input logic [127:0] rep, input logic [63:0] rep_len_w);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PATTERN_LOW;
        cfg_wdata <= pat[63:0];
        @(posedge aclk);
        cfg_index <= CFG_PATTERN_HIGH;
        cfg_wdata <= pat[127:64];
        @(posedge aclk);
        cfg_index <= CFG_PATTERN_LENGTH;
        cfg_wdata <= pat_len_w;
        @(posedge aclk);
        cfg_index <= CFG_REPLACEMENT_LOW;
        cfg_wdata <= rep[63:0];
        @(posedge aclk);
        cfg_index <= CFG_REPLACEMENT_HIGH;
        cfg_wdata <= rep[127:64];
        @(posedge aclk);
        cfg_index <= CFG_REPLACEMENT_LEN;
        cfg_wdata <= rep_len_w;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_item(input logic [7:0] b, input logic is_last);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= '{in_byte: b, in_last: is_last};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // leaves room for an input still being absorbed before the next write
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
        repeat (4) @(posedge aclk);
    endtask

    initial begin : receiver
        int gap;
        int got;
        got = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (got == 150 || got == 350) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            gap = ((got / 40) % 3 == 2) ? 0 : $urandom_range(0, 4);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            got++;
        end
    end

    initial begin : watchdog
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [127:0] pat;
        logic [127:0] rep;
        logic [63:0]  pat_len_w;
        logic [63:0]  rep_len_w;
        logic [7:0]   sym [3];
        logic [7:0]   text [$];
        int           eff;
        int           stream_len;
        int           phase_sent;
        int           p;
        int           k;
        int           pick;
        int           cut;

        sender_calm = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // zero byte as pattern, deleted; final byte leaves an empty end marker
        load_setting(128'h0, 64'd1, 128'h0, 64'd0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b1);
        drain();

        // two-byte pattern with a miss, a hit and a flushed tail
        load_setting(128'h4241, 64'd2, 128'h7A7978, 64'd3);
        send_item(8'h41, 1'b0);
        send_item(8'h41, 1'b0);
        send_item(8'h42, 1'b0);
        send_item(8'h43, 1'b1);
        drain();

        // both lengths above range, full 16-byte match
        load_setting({128{1'b1}}, 64'd31, 128'h8F8E8D8C8B8A89888786858483828180, 64'd31);
        for (k = 0; k < 16; k++) send_item(8'hFF, k == 15);
        drain();

        // zero pattern length, then a length change inside an open stream
        load_setting(128'h41, 64'd0, 128'h7170, 64'd2);
        send_item(8'h41, 1'b0);
        drain();
        load_setting(128'h41, 64'd2, 128'h72, 64'd1);
        send_item(8'h41, 1'b1);
        send_item(8'h41, 1'b0);
        send_item(8'h41, 1'b1);
        drain();

        for (p = 0; p < 6; p++) begin
            for (k = 0; k < 3; k++) sym[k] = 8'($urandom_range(0, 255));
            pat       = {$urandom, $urandom, $urandom, $urandom};
            rep       = {$urandom, $urandom, $urandom, $urandom};
            pat_len_w = {$urandom, $urandom};
            rep_len_w = {$urandom, $urandom};
            case (p)
                0:       pat_len_w[4:0] = 5'($urandom_range(1, 3));
                1:       pat_len_w[4:0] = 5'd16;
                2:       pat_len_w[4:0] = 5'd0;
                3:       pat_len_w[4:0] = 5'($urandom_range(2, 6));
                4:       pat_len_w[4:0] = 5'($urandom_range(17, 31));
                default: pat_len_w[4:0] = 5'($urandom_range(1, 4));
            endcase
            case (p)
                2:       rep_len_w[4:0] = 5'd0;
                4:       rep_len_w[4:0] = 5'd31;
                5:       rep_len_w[4:0] = 5'd16;
                default: rep_len_w[4:0] = 5'($urandom_range(0, 16));
            endcase
            eff = (pat_len_w[4:0] == 0) ? 1 :
                  ((pat_len_w[4:0] > 16) ? 16 : int'(pat_len_w[4:0]));
            for (k = 0; k < eff; k++) pat[8*k +: 8] = sym[$urandom_range(0, 2)];
            load_setting(pat, pat_len_w, rep, rep_len_w);

            phase_sent = 0;
            while (phase_sent < 60) begin
                text.delete();
                stream_len = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                         : $urandom_range(1, 12);
                while (text.size() < stream_len) begin
                    pick = $urandom_range(0, 9);
                    if (pick < 3) begin
                        for (k = 0; k < eff; k++) text.push_back(pat[8*k +: 8]);
                    end else if (pick == 3 && eff > 1) begin
                        // broken occurrence: a prefix of the pattern only
                        cut = $urandom_range(1, eff - 1);
                        for (k = 0; k < cut; k++) text.push_back(pat[8*k +: 8]);
                    end else if (pick < 7) begin
                        text.push_back(sym[$urandom_range(0, 2)]);
                    end else begin
                        text.push_back(8'($urandom_range(0, 255)));
                    end
                end
                sender_calm = ($urandom_range(0, 3) == 0);
                for (k = 0; k < text.size(); k++) send_item(text[k], k == text.size() - 1);
                phase_sent += text.size();
            end
            sender_calm = 1'b0;
            drain();
        end

        repeat (16) @(posedge aclk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
